### rtl/shell_background_splitter_defines.svh
// assertion macros for the background splitter checker
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef SHELL_BACKGROUND_SPLITTER_DEFINES_SVH
`define SHELL_BACKGROUND_SPLITTER_DEFINES_SVH

// same-cycle implication, off while in reset
`define SBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbs check failed: same-cycle rule");

// next-cycle implication, off while in reset
`define SBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbs check failed: next-cycle rule");

`endif

### rtl/sbs_pkg.sv
// shared types, character codes and defaults for the background splitter
// no dependencies
package sbs_pkg;

  localparam int MAX_NEST_DEF    = 15;
  localparam int SPACE_DEPTH_DEF = 16;
  localparam int Q_DEPTH         = 4;

  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    ACT_ADD,
    ACT_CUT,
    ACT_MARK
  } act_kind_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    act_kind_t  kind;
    logic [7:0] data;
  } action_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

### rtl/shell_background_splitter.sv
// a byte is judged when the next byte arrives (the final byte in the FE_LAST state), and its
// action passes through the queue entry register and then the output register
// throughput: 1 byte per cycle while in_stall is low; a swallowed pair byte or a line end
// stalls the front, and flushed blanks or the " &" suffix the back, absorbed by a 4-entry queue
// reset: synchronous, active low; clears control state, whitespace ram is not cleared
// top level: sbs_front -> sbs_queue -> sbs_back; uses sbs_pkg
module shell_background_splitter #(
  parameter int MAX_NEST    = sbs_pkg::MAX_NEST_DEF,
  parameter int SPACE_DEPTH = sbs_pkg::SPACE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_line_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_segment_end,
  output logic       out_line_end,
  output logic       out_space_overflow
);

  logic             push;
  sbs_pkg::action_t push_act;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  sbs_pkg::action_t head;

  sbs_front #(
    .MAX_NEST (MAX_NEST)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_line_last (in_line_last),
    .push         (push),
    .push_act     (push_act),
    .q_full       (q_full)
  );

  sbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_act (push_act),
    .pop      (pop),
    .q_full   (q_full),
    .q_empty  (q_empty),
    .head     (head)
  );

  sbs_back #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_has_byte       (out_has_byte),
    .out_segment_end    (out_segment_end),
    .out_line_end       (out_line_end),
    .out_space_overflow (out_space_overflow)
  );

endmodule

### rtl/sbs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/sbs_front.sv
// front end: accepts bytes, tracks quotes, nesting and lookahead, and
// turns each judged byte into an action for the back end; uses sbs_pkg
module sbs_front #(
  parameter int MAX_NEST = sbs_pkg::MAX_NEST_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_line_last,
  output logic              push,
  output sbs_pkg::action_t  push_act,
  input  logic              q_full
);

  localparam int LW = $clog2(MAX_NEST + 1);
  localparam logic [LW-1:0] LEVEL_MAX = LW'(MAX_NEST);

  typedef enum logic [1:0] {
    FE_RUN,
    FE_SWAL,
    FE_LAST,
    FE_MARK
  } fe_state_t;

  fe_state_t     state_r, state_nxt;
  logic [7:0]    held_byte_r, held_byte_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [7:0]    back_one_r, back_one_nxt;
  logic [7:0]    back_two_r, back_two_nxt;
  logic          quoting_r, quoting_nxt;
  logic          quote_dbl_r, quote_dbl_nxt;
  logic [LW-1:0] arith_r, arith_nxt;
  logic [LW-1:0] bracket_r, bracket_nxt;
  logic          last_r, last_nxt;

  // judge results for the held byte
  logic          j_has_next;
  logic [7:0]    j_nx;
  logic          j_cut;
  logic          j_swallow;
  logic          j_quoting;
  logic          j_quote_dbl;
  logic [LW-1:0] j_arith;
  logic [LW-1:0] j_bracket;
  logic          j_is_dq;
  logic          j_fd_next;

  assign j_has_next = (state_r == FE_RUN);
  assign j_nx       = j_has_next ? in_byte : sbs_pkg::CH_NUL;
  assign j_is_dq    = (held_byte_r == sbs_pkg::CH_DQUOTE);
  assign j_fd_next  = j_has_next && (sbs_pkg::is_digit(j_nx) || (j_nx == sbs_pkg::CH_MINUS));

  always_comb begin
    j_cut       = 1'b0;
    j_swallow   = 1'b0;
    j_quoting   = quoting_r;
    j_quote_dbl = quote_dbl_r;
    j_arith     = arith_r;
    j_bracket   = bracket_r;
    priority if (((held_byte_r == sbs_pkg::CH_DQUOTE) || (held_byte_r == sbs_pkg::CH_SQUOTE))
                 && (back_one_r != sbs_pkg::CH_BSLASH)) begin
      // raw backslash test, escaped backslashes are not looked at
      if (!quoting_r) begin
        j_quoting   = 1'b1;
        j_quote_dbl = j_is_dq;
      end else if (quote_dbl_r == j_is_dq) begin
        j_quoting   = 1'b0;
        j_quote_dbl = 1'b0;
      end
    end else if (quoting_r) begin
      j_cut = 1'b0;
    end else if ((back_two_r == sbs_pkg::CH_DOLLAR) && (back_one_r == sbs_pkg::CH_LPAREN)
                 && (held_byte_r == sbs_pkg::CH_LPAREN)) begin
      if (arith_r < LEVEL_MAX) begin
        j_arith = arith_r + LW'(1);
      end
    end else if (j_has_next && (held_byte_r == sbs_pkg::CH_RPAREN)
                 && (j_nx == sbs_pkg::CH_RPAREN) && (arith_r != '0)) begin
      j_arith   = arith_r - LW'(1);
      j_swallow = 1'b1;
    end else if (j_has_next && (held_byte_r == sbs_pkg::CH_LBRACK)
                 && (j_nx == sbs_pkg::CH_LBRACK)) begin
      if (bracket_r < LEVEL_MAX) begin
        j_bracket = bracket_r + LW'(1);
      end
      j_swallow = 1'b1;
    end else if (j_has_next && (held_byte_r == sbs_pkg::CH_RBRACK)
                 && (j_nx == sbs_pkg::CH_RBRACK) && (bracket_r != '0)) begin
      j_bracket = bracket_r - LW'(1);
      j_swallow = 1'b1;
    end else if ((held_byte_r == sbs_pkg::CH_AMP) && (arith_r == '0) && (bracket_r == '0)) begin
      priority if (j_has_next && (j_nx == sbs_pkg::CH_AMP)) begin
        j_swallow = 1'b1;
      end else if (((back_one_r == sbs_pkg::CH_GT) || (back_one_r == sbs_pkg::CH_LT))
                   && j_fd_next) begin
        j_cut = 1'b0;
      end else if (j_has_next && (j_nx == sbs_pkg::CH_GT)) begin
        j_cut = 1'b0;
      end else begin
        j_cut = 1'b1;
      end
    end else begin
      j_cut = 1'b0;
    end
  end

  assign in_stall = (state_r != FE_RUN) || q_full;

  always_comb begin
    state_nxt      = state_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    back_one_nxt   = back_one_r;
    back_two_nxt   = back_two_r;
    quoting_nxt    = quoting_r;
    quote_dbl_nxt  = quote_dbl_r;
    arith_nxt      = arith_r;
    bracket_nxt    = bracket_r;
    last_nxt       = last_r;
    push           = 1'b0;
    push_act.kind  = j_cut ? sbs_pkg::ACT_CUT : sbs_pkg::ACT_ADD;
    push_act.data  = held_byte_r;
    unique case (state_r)
      FE_RUN: begin
        if (in_valid && !q_full) begin
          held_byte_nxt = in_byte;
          if (held_valid_r) begin
            push          = 1'b1;
            back_two_nxt  = back_one_r;
            back_one_nxt  = held_byte_r;
            quoting_nxt   = j_quoting;
            quote_dbl_nxt = j_quote_dbl;
            arith_nxt     = j_arith;
            bracket_nxt   = j_bracket;
            if (j_swallow) begin
              // second byte of a pair goes in unjudged from FE_SWAL
              held_valid_nxt = 1'b0;
              last_nxt       = in_line_last;
              state_nxt      = FE_SWAL;
            end else begin
              held_valid_nxt = 1'b1;
              state_nxt      = in_line_last ? FE_LAST : FE_RUN;
            end
          end else begin
            held_valid_nxt = 1'b1;
            state_nxt      = in_line_last ? FE_LAST : FE_RUN;
          end
        end
      end
      FE_SWAL: begin
        if (!q_full) begin
          push          = 1'b1;
          push_act.kind = sbs_pkg::ACT_ADD;
          back_two_nxt  = back_one_r;
          back_one_nxt  = held_byte_r;
          state_nxt     = last_r ? FE_MARK : FE_RUN;
        end
      end
      FE_LAST: begin
        if (!q_full) begin
          push           = 1'b1;
          back_two_nxt   = back_one_r;
          back_one_nxt   = held_byte_r;
          quoting_nxt    = j_quoting;
          quote_dbl_nxt  = j_quote_dbl;
          arith_nxt      = j_arith;
          bracket_nxt    = j_bracket;
          held_valid_nxt = 1'b0;
          state_nxt      = FE_MARK;
        end
      end
      FE_MARK: begin
        if (!q_full) begin
          push           = 1'b1;
          push_act.kind  = sbs_pkg::ACT_MARK;
          push_act.data  = sbs_pkg::CH_NUL;
          held_byte_nxt  = sbs_pkg::CH_NUL;
          held_valid_nxt = 1'b0;
          back_one_nxt   = sbs_pkg::CH_NUL;
          back_two_nxt   = sbs_pkg::CH_NUL;
          quoting_nxt    = 1'b0;
          quote_dbl_nxt  = 1'b0;
          arith_nxt      = '0;
          bracket_nxt    = '0;
          state_nxt      = FE_RUN;
        end
      end
      default: state_nxt = FE_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FE_RUN;
      held_byte_r  <= sbs_pkg::CH_NUL;
      held_valid_r <= 1'b0;
      back_one_r   <= sbs_pkg::CH_NUL;
      back_two_r   <= sbs_pkg::CH_NUL;
      quoting_r    <= 1'b0;
      quote_dbl_r  <= 1'b0;
      arith_r      <= '0;
      bracket_r    <= '0;
      last_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      back_one_r   <= back_one_nxt;
      back_two_r   <= back_two_nxt;
      quoting_r    <= quoting_nxt;
      quote_dbl_r  <= quote_dbl_nxt;
      arith_r      <= arith_nxt;
      bracket_r    <= bracket_nxt;
      last_r       <= last_nxt;
    end
  end

endmodule

### rtl/sbs_queue.sv
// short action queue between front and back end
// uses sbs_pkg for the action type and depth
module sbs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sbs_pkg::action_t  push_act,
  input  logic              pop,
  output logic              q_full,
  output logic              q_empty,
  output sbs_pkg::action_t  head
);

  localparam int QAW = $clog2(sbs_pkg::Q_DEPTH);
  localparam int QCW = $clog2(sbs_pkg::Q_DEPTH + 1);

  sbs_pkg::action_t entry_r [sbs_pkg::Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_full  = (count_r == QCW'(sbs_pkg::Q_DEPTH));
  assign q_empty = (count_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(sbs_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(sbs_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_act;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/sbs_back.sv
// back end: trims whitespace, flushes held interior blanks, adds the " &"
// suffix and line markers, and drives the output register; uses sbs_pkg, sbs_ram
module sbs_back #(
  parameter int SPACE_DEPTH = sbs_pkg::SPACE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sbs_pkg::action_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_has_byte,
  output logic              out_segment_end,
  output logic              out_line_end,
  output logic              out_space_overflow
);

  localparam int AW = $clog2(SPACE_DEPTH);
  localparam int CW = $clog2(SPACE_DEPTH + 2);
  localparam logic [CW-1:0] DEPTH_C = CW'(SPACE_DEPTH);
  localparam logic [CW-1:0] OVF_C   = CW'(SPACE_DEPTH + 1);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FLUSH,
    BK_CHAR,
    BK_AMP
  } bk_state_t;

  bk_state_t     state_r, state_nxt;
  logic          seg_open_r, seg_open_nxt;
  logic          last_amp_r, last_amp_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_has_r;
  logic          out_send_r;
  logic          out_lend_r;
  logic          out_ovf_r;

  logic          out_free;
  logic          emit;
  logic [7:0]    e_byte;
  logic          e_has;
  logic          e_send;
  logic          e_lend;
  logic          e_ovf;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          ovf;
  logic [CW-1:0] kept;
  logic          idx_last;

  assign out_free = !out_valid_r || !out_stall;
  assign ovf      = (count_r > DEPTH_C);
  assign kept     = ovf ? DEPTH_C : count_r;
  assign idx_last = ((CW'(idx_r) + CW'(1)) == kept);

  sbs_ram #(
    .WIDTH (8),
    .DEPTH (SPACE_DEPTH)
  ) u_space_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (head.data),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    seg_open_nxt = seg_open_r;
    last_amp_nxt = last_amp_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pop          = 1'b0;
    emit         = 1'b0;
    e_byte       = sbs_pkg::CH_NUL;
    e_has        = 1'b0;
    e_send       = 1'b0;
    e_lend       = 1'b0;
    e_ovf        = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (head.kind)
            sbs_pkg::ACT_ADD: begin
              if (sbs_pkg::is_blank(head.data)) begin
                pop = 1'b1;
                if (seg_open_r) begin
                  if (count_r < DEPTH_C) begin
                    ram_we    = 1'b1;
                    count_nxt = count_r + CW'(1);
                  end else begin
                    count_nxt = OVF_C;
                  end
                end
              end else if (seg_open_r && (count_r != '0)) begin
                // read of entry 0 is in flight for the flush
                state_nxt = BK_FLUSH;
                idx_nxt   = '0;
              end else if (out_free) begin
                emit         = 1'b1;
                e_byte       = head.data;
                e_has        = 1'b1;
                pop          = 1'b1;
                count_nxt    = '0;
                seg_open_nxt = 1'b1;
                last_amp_nxt = (head.data == sbs_pkg::CH_AMP);
              end
            end
            sbs_pkg::ACT_CUT: begin
              if (!seg_open_r) begin
                pop          = 1'b1;
                last_amp_nxt = 1'b0;
                count_nxt    = '0;
              end else if (last_amp_r) begin
                if (out_free) begin
                  emit         = 1'b1;
                  e_send       = 1'b1;
                  pop          = 1'b1;
                  seg_open_nxt = 1'b0;
                  last_amp_nxt = 1'b0;
                  count_nxt    = '0;
                end
              end else if (out_free) begin
                emit      = 1'b1;
                e_byte    = sbs_pkg::CH_SPACE;
                e_has     = 1'b1;
                state_nxt = BK_AMP;
              end
            end
            sbs_pkg::ACT_MARK: begin
              if (out_free) begin
                emit         = 1'b1;
                e_send       = seg_open_r;
                e_lend       = 1'b1;
                pop          = 1'b1;
                seg_open_nxt = 1'b0;
                last_amp_nxt = 1'b0;
                count_nxt    = '0;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      BK_FLUSH: begin
        ram_raddr = out_free ? idx_r + AW'(1) : idx_r;
        if (out_free) begin
          emit   = 1'b1;
          e_byte = ram_rdata;
          e_has  = 1'b1;
          e_ovf  = ovf;
          if (idx_last) begin
            state_nxt = BK_CHAR;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      BK_CHAR: begin
        if (out_free) begin
          emit         = 1'b1;
          e_byte       = head.data;
          e_has        = 1'b1;
          pop          = 1'b1;
          count_nxt    = '0;
          seg_open_nxt = 1'b1;
          last_amp_nxt = (head.data == sbs_pkg::CH_AMP);
          state_nxt    = BK_IDLE;
        end
      end
      BK_AMP: begin
        if (out_free) begin
          emit         = 1'b1;
          e_byte       = sbs_pkg::CH_AMP;
          e_has        = 1'b1;
          e_send       = 1'b1;
          pop          = 1'b1;
          seg_open_nxt = 1'b0;
          last_amp_nxt = 1'b0;
          count_nxt    = '0;
          state_nxt    = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= e_byte;
      out_has_r  <= e_has;
      out_send_r <= e_send;
      out_lend_r <= e_lend;
      out_ovf_r  <= e_ovf;
    end
    idx_r <= idx_nxt;
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      seg_open_r  <= 1'b0;
      last_amp_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seg_open_r <= seg_open_nxt;
      last_amp_r <= last_amp_nxt;
      count_r    <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_has_byte       = out_has_r;
  assign out_segment_end    = out_send_r;
  assign out_line_end       = out_lend_r;
  assign out_space_overflow = out_ovf_r;

endmodule

### rtl/sbs_checker.sv
// port-level checks for the background splitter, bound to the top level
// uses shell_background_splitter_defines.svh and sbs_pkg
`include "shell_background_splitter_defines.svh"

module sbs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       in_line_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic       out_segment_end,
  input logic       out_line_end,
  input logic       out_space_overflow
);

  // markers carry no byte
  `SBS_ASSERT_NOW(a_marker_zero, out_valid && !out_has_byte, out_byte == sbs_pkg::CH_NUL)
  // the line-end marker is always a bare marker
  `SBS_ASSERT_NOW(a_line_end_bare, out_valid && out_line_end, !out_has_byte)
  // a segment_end that carries a byte is the suffix ampersand
  `SBS_ASSERT_NOW(a_suffix_amp, out_valid && out_has_byte && out_segment_end, out_byte == sbs_pkg::CH_AMP)
  // overflow flags only flushed blanks
  `SBS_ASSERT_NOW(a_ovf_blank, out_valid && out_space_overflow, out_has_byte && !out_segment_end && sbs_pkg::is_blank(out_byte))
  // a stalled result holds
  `SBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte))

endmodule

bind shell_background_splitter sbs_checker u_sbs_checker (.*);
